// ----- src/pls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list store: request kinds,
// response status codes, back-end operation codes and the queued command.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int POS_W  = 8;
	localparam int WORD_W = 32;
	localparam int ECNT_W = 5;
	localparam int KIND_W = 3;
	localparam int ST_W   = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PREPEND      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ         = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVE       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_REMOVE_LAST  = 3'd6;

	// response status
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	typedef logic [1:0] op_t;

	// work for the back end
	localparam op_t OP_NOP = 2'd0;
	localparam op_t OP_INS = 2'd1;
	localparam op_t OP_DEL = 2'd2;
	localparam op_t OP_RD  = 2'd3;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  first;
		logic [POS_W-1:0]  last;
		logic [WORD_W-1:0] word;
		logic [ST_W-1:0]   status;
		logic [ECNT_W-1:0] ecount;
	} cmd_t;

endpackage
`default_nettype wire

// ----- src/pls_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pls_front
// Accepts requests, checks them against the running entry count and turns
// each one into a command for the back end with its final status and count.
// ----------------------------------------------------------------------------
module pls_front import pls_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [WORD_W-1:0] value,
	output cmd_t                   cmd,
	output logic                   cmd_push,
	input  wire logic              cmd_full
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_next;
	logic [CW-1:0] cnt_dec;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          is_full;
	logic          in_range;
	logic          non_empty;

	assign in_ready = !cmd_full;
	assign cmd_push = in_valid && !cmd_full;

	assign pos_x     = XW'(position);
	assign cnt_x     = XW'(count_q);
	assign cnt_dec   = count_q - CW'(1);
	assign is_full   = (count_q == CW'(CAPACITY));
	assign in_range  = (pos_x < cnt_x);
	assign non_empty = (count_q != '0);

	always_comb begin
		cmd        = '0;
		cmd.op     = OP_NOP;
		cmd.status = ST_OK;
		cmd.word   = value;
		cnt_next   = count_q;
		case (kind)
			KIND_INSERT, KIND_APPEND, KIND_PREPEND: begin
				if (is_full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.op   = OP_INS;
					cmd.last = POS_W'(count_q);
					cnt_next = count_q + CW'(1);
					if (kind == KIND_PREPEND) begin
						cmd.first = '0;
					end else if (kind == KIND_APPEND || pos_x > cnt_x) begin
						// insert past the end appends
						cmd.first = POS_W'(count_q);
					end else begin
						cmd.first = position;
					end
				end
			end
			KIND_READ: begin
				if (in_range) begin
					cmd.op    = OP_RD;
					cmd.first = position;
				end else begin
					cmd.status = ST_RANGE;
				end
			end
			KIND_REMOVE: begin
				if (in_range) begin
					cmd.op    = OP_DEL;
					cmd.first = position;
					cmd.last  = POS_W'(cnt_dec);
					cnt_next  = cnt_dec;
				end else begin
					cmd.status = ST_RANGE;
				end
			end
			KIND_REMOVE_FIRST, KIND_REMOVE_LAST: begin
				if (non_empty) begin
					cmd.op    = OP_DEL;
					cmd.first = (kind == KIND_REMOVE_LAST) ? POS_W'(cnt_dec) : '0;
					cmd.last  = POS_W'(cnt_dec);
					cnt_next  = cnt_dec;
				end else begin
					cmd.status = ST_RANGE;
				end
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
		cmd.ecount = ECNT_W'(cnt_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_push) begin
			count_q <= cnt_next;
		end
	end

endmodule
`default_nettype wire

// ----- src/pls_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pls_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pls_cmd_fifo import pls_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t       buf_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign head  = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ----- src/pls_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pls_back
// Carries out queued commands on the entry memory: shifts entries one at a
// time for insert and remove, reads for read, and holds the response.
// ----------------------------------------------------------------------------
module pls_back import pls_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cmd_t                    cmd,
	input  wire logic               cmd_empty,
	output logic                    cmd_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [WORD_W-1:0]       read_value,
	output logic [ECNT_W-1:0]       entry_count,
	output logic [ST_W-1:0]         status
);

	localparam int AW = $clog2(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q;
	op_t               op_q;
	logic [POS_W-1:0]  ptr_q;
	logic [POS_W-1:0]  end_q;
	logic [WORD_W-1:0] word_q;
	logic [ST_W-1:0]   st_q;
	logic [ECNT_W-1:0] ecnt_q;

	logic [WORD_W-1:0] mem [CAPACITY];
	logic [WORD_W-1:0] rdata_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic [ECNT_W-1:0] out_cnt_q;
	logic [ST_W-1:0]   out_st_q;

	logic [POS_W-1:0]  ptr_step;
	logic [POS_W-1:0]  raddr;
	logic [WORD_W-1:0] wdata;
	logic              re;
	logic              we;
	logic              out_load;

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// insert walks down from the tail, remove walks up from the hole
	assign ptr_step = (op_q == OP_INS) ? ptr_q - POS_W'(1) : ptr_q + POS_W'(1);

	always_comb begin
		case (op_q)
			OP_INS:  raddr = ptr_q - POS_W'(1);
			OP_DEL:  raddr = ptr_q + POS_W'(1);
			default: raddr = ptr_q;
		endcase
	end

	assign re    = (state_q == S_READ);
	assign we    = ((state_q == S_WRITE) && (op_q != OP_RD)) || (state_q == S_PUT);
	assign wdata = (state_q == S_PUT) ? word_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[ptr_q[AW-1:0]] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						case (cmd.op)
							OP_RD:   state_q <= S_READ;
							OP_INS:  state_q <= (cmd.first == cmd.last) ? S_PUT : S_READ;
							OP_DEL:  state_q <= (cmd.first == cmd.last) ? S_DONE : S_READ;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (op_q == OP_RD) begin
						state_q <= S_DONE;
					end else if (ptr_step == end_q) begin
						state_q <= (op_q == OP_INS) ? S_PUT : S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q   <= cmd.op;
			ptr_q  <= (cmd.op == OP_INS) ? cmd.last : cmd.first;
			end_q  <= (cmd.op == OP_INS) ? cmd.first : cmd.last;
			word_q <= cmd.word;
			st_q   <= cmd.status;
			ecnt_q <= cmd.ecount;
		end else if (state_q == S_WRITE && op_q != OP_RD) begin
			ptr_q <= ptr_step;
		end
		if (out_load) begin
			out_value_q <= (op_q == OP_RD) ? rdata_q : '0;
			out_cnt_q   <= ecnt_q;
			out_st_q    <= st_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = out_value_q;
	assign entry_count = out_cnt_q;
	assign status      = out_st_q;

endmodule
`default_nettype wire

// ----- src/positional_list_store.sv -----
`default_nettype none
// back-end states per request: S_DONE for a refused request or unused kind; a read runs
// S_READ, S_WRITE, S_DONE; an insert S_READ and S_WRITE per entry moved, then S_PUT and
// S_DONE; a remove S_READ and S_WRITE per entry moved, then S_DONE; one command at a time,
// moving one entry at a time through the single-port entry memory; two requests queue ahead
// reset clears the entry count, the command queue and the response valid flag;
// entry words are not cleared and are never read before being written
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed words addressed by position, with insert,
// append, prepend, read and remove requests and a count in every response.
// ----------------------------------------------------------------------------
module positional_list_store import pls_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // position[7:0], value[39:8]
	input  wire logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata   // read_value[31:0], entry_count[36:32],
	                                        // status[38:37], zero[39]
);

	cmd_t              fe_cmd;
	cmd_t              q_head;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	logic [WORD_W-1:0] read_value;
	logic [ECNT_W-1:0] entry_count;
	logic [ST_W-1:0]   status;

	pls_front #(.CAPACITY(CAPACITY)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.kind     (s_axis_tuser),
		.position (s_axis_tdata[7:0]),
		.value    (s_axis_tdata[39:8]),
		.cmd      (fe_cmd),
		.cmd_push (q_push),
		.cmd_full (q_full)
	);

	pls_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (fe_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	pls_back #(.CAPACITY(CAPACITY)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (q_head),
		.cmd_empty   (q_empty),
		.cmd_pop     (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.read_value  (read_value),
		.entry_count (entry_count),
		.status      (status)
	);

	assign m_axis_tdata = {1'b0, status, entry_count, read_value};

`ifndef NO_ASSERTIONS
	// a refused insert always reports a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status == ST_FULL) |-> (entry_count == ECNT_W'(CAPACITY)))
		else $error("full response with wrong entry count");

	// only a successful request can carry read data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status != ST_OK) |-> (read_value == '0))
		else $error("failed request returned read data");

	// status stays within its defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
		else $error("undefined status code");
`endif

endmodule
`default_nettype wire
